// ===== rtl/iiee_pkg.sv =====
package iiee_pkg;

  localparam int unsigned ValueWidthDef = 64;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [1:0] PhOperand = 2'd0;
  localparam logic [1:0] PhUnary   = 2'd1;
  localparam logic [1:0] PhDigits  = 2'd2;
  localparam logic [1:0] PhAfter   = 2'd3;

  localparam logic [1:0] MdNone = 2'd0;
  localparam logic [1:0] MdMul  = 2'd1;
  localparam logic [1:0] MdDiv  = 2'd2;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StBad    = 2'd1;
  localparam logic [1:0] StDivZer = 2'd2;

endpackage

// ===== rtl/iiee_in_if.sv =====
interface iiee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       ends_expression;

  modport source (output valid, output symbol, output ends_expression, input ready);
  modport sink (input valid, input symbol, input ends_expression, output ready);
endinterface

// ===== rtl/iiee_out_if.sv =====
interface iiee_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [1:0]         status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

// ===== rtl/infix_integer_expression_evaluator.sv =====
// Channel  Port   Dir  Beat
// chars    sym_i  in   symbol[7:0], ends_expression
// result   res_o  out  value[63:0] signed, status[1:0]
//
// A character beat is taken in S_IDLE; one that closes a numeral passes S_FIN,
// then S_MUL or S_DIV if a multiply or divide is pending, and S_REPLAY. The
// shared shift-add / restoring-divide unit retires one bit per cycle. Reset
// clears FSM and parse state only; no clearing pass. The result sits in an
// output register; sym_i stalls while it is full and not taken, or not idle.
module infix_integer_expression_evaluator
  import iiee_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  iiee_in_if.sink    sym_i,
  iiee_out_if.source res_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;
  localparam logic [W+3:0] LimPos = {5'b0, {(W-1){1'b1}}};
  localparam logic [W+3:0] LimNeg = LimPos + 1'b1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIN    = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_REPLAY = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [W-1:0]  sum_q, sum_d, term_q, term_d, mag_q, mag_d;
  logic          neg_q, neg_d, as_q, as_d;
  logic [1:0]    md_q, md_d, ph_q, ph_d, err_q, err_d;
  logic [7:0]    sc_q, sc_d;
  logic          se_q, se_d;
  logic [W-1:0]  acc_q, acc_d, opa_q, opa_d, opb_q, opb_d;
  logic          dneg_q, dneg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          oval_q, oval_d;
  logic signed [63:0] oval_val_q, oval_val_d;
  logic [1:0]    ost_q, ost_d;

  logic          slot_ok, in_fire, do_proc, need_fin;
  logic [7:0]    c;
  logic          e;
  logic          is_digit, is_op;
  logic [W+3:0]  new10;
  logic [W-1:0]  fold, v, qa, qb;
  logic [1:0]    err_end;
  logic [W:0]    trial;

  assign slot_ok     = !oval_q || res_o.ready;
  assign sym_i.ready = (state_q == S_IDLE) && slot_ok;
  assign in_fire     = sym_i.valid && sym_i.ready;
  assign res_o.valid  = oval_q;
  assign res_o.value  = oval_val_q;
  assign res_o.status = ost_q;

  always_comb begin
    c        = (state_q == S_IDLE) ? sym_i.symbol : sc_q;
    e        = (state_q == S_IDLE) ? sym_i.ends_expression : se_q;
    do_proc  = in_fire || ((state_q == S_REPLAY) && slot_ok);
    is_digit = c inside {[ChZero:ChNine]};
    is_op    = c inside {ChPlus, ChMinus, ChStar, ChSlash};
    need_fin = (err_q != StBad) && (ph_q == PhDigits) && (e || c == ChSpace || is_op);
    new10    = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {{W{1'b0}}, c[3:0]};
    fold     = as_q ? (sum_q - term_q) : (sum_q + term_q);
    v        = neg_q ? (~mag_q + 1'b1) : mag_q;
    qa       = term_q[W-1] ? (~term_q + 1'b1) : term_q;
    qb       = v[W-1] ? (~v + 1'b1) : v;
    trial    = {opa_q, opb_q[W-1]};
    err_end  = err_q;

    state_d = state_q; sum_d = sum_q; term_d = term_q; mag_d = mag_q;
    neg_d = neg_q; as_d = as_q; md_d = md_q; ph_d = ph_q; err_d = err_q;
    sc_d = sc_q; se_d = se_q; acc_d = acc_q; opa_d = opa_q; opb_d = opb_q;
    dneg_d = dneg_q; cnt_d = cnt_q;
    oval_d = oval_q && !res_o.ready;
    oval_val_d = oval_val_q; ost_d = ost_q;

    case (state_q)
      S_FIN: begin
        mag_d = '0; neg_d = 1'b0; md_d = MdNone; ph_d = PhAfter;
        cnt_d = CW'(W - 1);
        state_d = S_REPLAY;
        case (md_q)
          MdMul: begin
            acc_d = '0; opa_d = term_q; opb_d = v; state_d = S_MUL;
          end
          MdDiv: begin
            if (v == '0) begin
              if (err_q == StOk) err_d = StDivZer;
              term_d = '0;
            end else begin
              opa_d = '0; acc_d = qb; opb_d = qa;
              dneg_d = term_q[W-1] ^ v[W-1];
              state_d = S_DIV;
            end
          end
          default: term_d = v;
        endcase
      end
      S_MUL: begin
        if (opb_q[0]) acc_d = acc_q + opa_q;
        opa_d = opa_q << 1;
        opb_d = opb_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          term_d  = opb_q[0] ? (acc_q + opa_q) : acc_q;
          state_d = S_REPLAY;
        end
      end
      S_DIV: begin
        // opa: remainder, opb: dividend shifting into quotient, acc: divisor
        if (trial >= {1'b0, acc_q}) begin
          opa_d = W'(trial - {1'b0, acc_q});
          opb_d = {opb_q[W-2:0], 1'b1};
        end else begin
          opa_d = trial[W-1:0];
          opb_d = {opb_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          term_d  = dneg_q ? (~opb_d + 1'b1) : opb_d;
          state_d = S_REPLAY;
        end
      end
      default: ;
    endcase

    if (do_proc) begin
      state_d = S_IDLE;
      if (need_fin) begin
        sc_d = c; se_d = e; state_d = S_FIN;
      end else if (e) begin
        if (err_q != StBad) begin
          if (ph_q == PhAfter) sum_d = fold;
          else err_end = StBad;
        end
        oval_d     = 1'b1;
        ost_d      = err_end;
        oval_val_d = (err_end == StOk) ? 64'($signed((ph_q == PhAfter) ? fold : sum_q))
                                       : '0;
        if (err_q == StBad) oval_val_d = '0;
        sum_d = '0; term_d = '0; mag_d = '0; neg_d = 1'b0; md_d = MdNone;
        as_d = 1'b0; ph_d = PhOperand; err_d = StOk;
      end else if (err_q == StBad) begin
      end else if (is_digit) begin
        if (ph_q != PhAfter && new10 <= (neg_q ? LimNeg : LimPos)) begin
          mag_d = new10[W-1:0]; ph_d = PhDigits;
        end else begin
          err_d = StBad;
        end
      end else if (c == ChSpace) begin
      end else if (ph_q == PhOperand) begin
        if (c == ChMinus) begin
          neg_d = 1'b1; ph_d = PhUnary;
        end else begin
          err_d = StBad;
        end
      end else if (ph_q == PhUnary) begin
        err_d = StBad;
      end else if (is_op) begin
        if (c == ChPlus || c == ChMinus) begin
          sum_d = fold; term_d = '0; as_d = (c == ChMinus); md_d = MdNone;
        end else begin
          md_d = (c == ChStar) ? MdMul : MdDiv;
        end
        ph_d = PhOperand;
      end else begin
        err_d = StBad;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sum_q <= '0; term_q <= '0; mag_q <= '0; neg_q <= 1'b0; as_q <= 1'b0;
      md_q <= MdNone; ph_q <= PhOperand; err_q <= StOk; oval_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      sum_q <= sum_d; term_q <= term_d; mag_q <= mag_d; neg_q <= neg_d; as_q <= as_d;
      md_q <= md_d; ph_q <= ph_d; err_q <= err_d; oval_q <= oval_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sc_q <= sc_d; se_q <= se_d; acc_q <= acc_d; opa_q <= opa_d; opb_q <= opb_d;
    dneg_q <= dneg_d; oval_val_q <= oval_val_d; ost_q <= ost_d;
  end

endmodule
